// ===== sv/u16rb_pkg.sv =====
// shared types, constants and pointer helpers for the 16550 register block
package u16rb_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int TMO_W      = 10;

    localparam logic [TMO_W-1:0] TMO_RESET = 10'd64;
    localparam logic [TMO_W-1:0] TMO_MAX   = 10'd1023;

    // operation codes
    localparam logic [2:0] OP_BUS_READ  = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE = 3'd1;
    localparam logic [2:0] OP_RX_BYTE   = 3'd2;
    localparam logic [2:0] OP_TX_READY  = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // register offsets
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_LSR  = 3'd5;

    // interrupt identification codes
    localparam logic [7:0] IIR_RX_DATA = 8'h04;
    localparam logic [7:0] IIR_TIMEOUT = 8'h0c;
    localparam logic [7:0] IIR_THRE    = 8'h02;
    localparam logic [7:0] IIR_NONE    = 8'h01;
    localparam logic [7:0] IIR_FIFO_ON = 8'hc0;

    // bit positions and masks
    localparam int LCR_DLAB   = 7;
    localparam int IER_RDA    = 0;
    localparam int IER_THRE   = 1;
    localparam int FCR_ENABLE = 0;
    localparam int FCR_RX_CLR = 1;
    localparam int FCR_TX_CLR = 2;
    localparam logic [7:0] LSR_DR    = 8'h01;
    localparam logic [7:0] LSR_OE    = 8'h02;
    localparam logic [7:0] LSR_EMPTY = 8'h60;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq;
    } result_t;

    // word waiting for the fifo read data
    typedef struct packed {
        logic [7:0] reg_data;
        logic       use_rx;
        logic       use_tx;
        logic       irq;
    } stage_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(p) + SUM_W'(n);
        if (sum >= SUM_W'(FIFO_DEPTH))
            sum = sum - SUM_W'(FIFO_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== sv/u16rb_ram.sv =====
// byte store for one fifo, one write and one registered read per cycle
module u16rb_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [u16rb_pkg::PTR_W-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic                        re,
    input  logic [u16rb_pkg::PTR_W-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [u16rb_pkg::FIFO_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/uart_16550_register_block.sv =====
// register side of a 16550-style uart with receive and transmit fifos
//
//  channel   direction  handshake               word
//  in        input      in_valid / in_ready     in_data  (item_t)
//  out       output     out_valid / out_ready   out_data (result_t)
//  cfg       input      cfg_we                  cfg_wdata (rx timeout ticks)
//
// one word per cycle while out_ready is high; each word passes s1_reg, then out_data_reg
// control state updates at acceptance, fifo bytes come from a registered ram read
// a push never shares a cycle with a pop of the same fifo, so no forwarding
// reset loads TMO_RESET, clears other control state; fifo contents are undefined until written
// an output stall is absorbed by one stage before in_ready drops
module uart_16550_register_block (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  u16rb_pkg::item_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output u16rb_pkg::result_t         out_data,
    input  logic                       cfg_we,
    input  logic [u16rb_pkg::TMO_W-1:0] cfg_wdata
);

    localparam int PW = u16rb_pkg::PTR_W;
    localparam int CW = u16rb_pkg::CNT_W;
    localparam int TW = u16rb_pkg::TMO_W;

    logic [TW-1:0] tmo_limit_reg;
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [PW-1:0] rx_head_reg, rx_head_next;
    logic [CW-1:0] tx_count_reg, tx_count_next;
    logic [PW-1:0] tx_head_reg, tx_head_next;
    logic [3:0]    ier_reg, ier_next;
    logic [7:0]    lcr_reg, lcr_next;
    logic [15:0]   divisor_reg, divisor_next;
    logic          fifo_on_reg, fifo_on_next;
    logic          thre_reg, thre_next;
    logic          overrun_reg, overrun_next;
    logic [TW-1:0] idle_ticks_reg, idle_ticks_next;
    logic          timeout_reg, timeout_next;

    logic                s1_valid_reg;
    u16rb_pkg::stage_t   s1_reg, s1_next;
    logic                out_valid_reg;
    u16rb_pkg::result_t  out_data_reg, out_comb;

    logic          accept;
    logic          out_ld;
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [PW-1:0] rx_waddr, tx_waddr;
    logic [7:0]    rx_rdata, tx_rdata;
    logic [CW-1:0] cap;
    logic          latch;
    logic [7:0]    cause_now;

    function automatic logic [7:0] cause_of(input logic [3:0] ier, input logic rx_any,
                                            input logic tmo, input logic thre);
        if (ier[u16rb_pkg::IER_RDA] && rx_any)
            return u16rb_pkg::IIR_RX_DATA;
        if (ier[u16rb_pkg::IER_RDA] && tmo)
            return u16rb_pkg::IIR_TIMEOUT;
        if (ier[u16rb_pkg::IER_THRE] && thre)
            return u16rb_pkg::IIR_THRE;
        return u16rb_pkg::IIR_NONE;
    endfunction

    assign out_ld   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_ld;
    assign accept   = in_valid && in_ready;

    assign cap       = fifo_on_reg ? CW'(u16rb_pkg::FIFO_DEPTH) : CW'(1);
    assign latch     = lcr_reg[u16rb_pkg::LCR_DLAB];
    assign cause_now = cause_of(ier_reg, rx_count_reg != '0, timeout_reg, thre_reg);
    assign rx_waddr  = u16rb_pkg::ptr_add(rx_head_reg, rx_count_reg);
    assign tx_waddr  = u16rb_pkg::ptr_add(tx_head_reg, tx_count_reg);

    always_comb
    begin
        rx_count_next   = rx_count_reg;
        rx_head_next    = rx_head_reg;
        tx_count_next   = tx_count_reg;
        tx_head_next    = tx_head_reg;
        ier_next        = ier_reg;
        lcr_next        = lcr_reg;
        divisor_next    = divisor_reg;
        fifo_on_next    = fifo_on_reg;
        thre_next       = thre_reg;
        overrun_next    = overrun_reg;
        idle_ticks_next = idle_ticks_reg;
        timeout_next    = timeout_reg;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        s1_next         = '0;

        if (accept)
        begin
            case (in_data.operation)
                u16rb_pkg::OP_BUS_READ:
                begin
                    case (in_data.reg_offset)
                        u16rb_pkg::REG_DATA:
                        begin
                            if (latch)
                            begin
                                s1_next.reg_data = divisor_reg[7:0];
                            end
                            else
                            begin
                                if (rx_count_reg != '0)
                                begin
                                    rx_re          = 1'b1;
                                    s1_next.use_rx = 1'b1;
                                    rx_head_next   = u16rb_pkg::ptr_inc(rx_head_reg);
                                    rx_count_next  = rx_count_reg - CW'(1);
                                end
                                idle_ticks_next = '0;
                                timeout_next    = 1'b0;
                            end
                        end
                        u16rb_pkg::REG_IER:
                        begin
                            s1_next.reg_data = latch ? divisor_reg[15:8] : {4'd0, ier_reg};
                        end
                        u16rb_pkg::REG_IIR:
                        begin
                            if (cause_now == u16rb_pkg::IIR_THRE)
                            begin
                                thre_next = 1'b0;
                            end
                            s1_next.reg_data = cause_now
                                | (fifo_on_reg ? u16rb_pkg::IIR_FIFO_ON : 8'h00);
                        end
                        u16rb_pkg::REG_LCR:
                        begin
                            s1_next.reg_data = lcr_reg;
                        end
                        u16rb_pkg::REG_LSR:
                        begin
                            s1_next.reg_data =
                                  ((rx_count_reg != '0) ? u16rb_pkg::LSR_DR : 8'h00)
                                | (overrun_reg ? u16rb_pkg::LSR_OE : 8'h00)
                                | ((tx_count_reg == '0) ? u16rb_pkg::LSR_EMPTY : 8'h00);
                            overrun_next = 1'b0;
                        end
                        default:
                        begin
                            s1_next.reg_data = 8'h00;
                        end
                    endcase
                end
                u16rb_pkg::OP_BUS_WRITE:
                begin
                    case (in_data.reg_offset)
                        u16rb_pkg::REG_DATA:
                        begin
                            if (latch)
                            begin
                                divisor_next[7:0] = in_data.write_data;
                            end
                            else
                            begin
                                if (tx_count_reg < cap)
                                begin
                                    tx_we         = 1'b1;
                                    tx_count_next = tx_count_reg + CW'(1);
                                end
                                thre_next = 1'b0;
                            end
                        end
                        u16rb_pkg::REG_IER:
                        begin
                            if (latch)
                            begin
                                divisor_next[15:8] = in_data.write_data;
                            end
                            else
                            begin
                                if (in_data.write_data[u16rb_pkg::IER_THRE]
                                    && !ier_reg[u16rb_pkg::IER_THRE]
                                    && tx_count_reg == '0)
                                begin
                                    thre_next = 1'b1;
                                end
                                ier_next = in_data.write_data[3:0];
                            end
                        end
                        u16rb_pkg::REG_IIR:
                        begin
                            // mode change flushes both fifos; each clear bit flushes its own fifo
                            if (in_data.write_data[u16rb_pkg::FCR_ENABLE] != fifo_on_reg
                                || in_data.write_data[u16rb_pkg::FCR_RX_CLR])
                            begin
                                rx_count_next   = '0;
                                rx_head_next    = '0;
                                idle_ticks_next = '0;
                                timeout_next    = 1'b0;
                            end
                            if (in_data.write_data[u16rb_pkg::FCR_ENABLE] != fifo_on_reg
                                || in_data.write_data[u16rb_pkg::FCR_TX_CLR])
                            begin
                                tx_count_next = '0;
                                tx_head_next  = '0;
                                thre_next     = 1'b1;
                            end
                            fifo_on_next = in_data.write_data[u16rb_pkg::FCR_ENABLE];
                        end
                        u16rb_pkg::REG_LCR:
                        begin
                            lcr_next = in_data.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                u16rb_pkg::OP_RX_BYTE:
                begin
                    if (rx_count_reg < cap)
                    begin
                        rx_we         = 1'b1;
                        rx_count_next = rx_count_reg + CW'(1);
                    end
                    else
                    begin
                        overrun_next = 1'b1;
                    end
                    idle_ticks_next = '0;
                    timeout_next    = 1'b0;
                end
                u16rb_pkg::OP_TX_READY:
                begin
                    if (tx_count_reg != '0)
                    begin
                        tx_re          = 1'b1;
                        s1_next.use_tx = 1'b1;
                        tx_head_next   = u16rb_pkg::ptr_inc(tx_head_reg);
                        tx_count_next  = tx_count_reg - CW'(1);
                        if (tx_count_reg == CW'(1))
                        begin
                            thre_next = 1'b1;
                        end
                    end
                end
                u16rb_pkg::OP_TICK:
                begin
                    if (rx_count_reg != '0)
                    begin
                        if (idle_ticks_reg != u16rb_pkg::TMO_MAX)
                        begin
                            idle_ticks_next = idle_ticks_reg + TW'(1);
                        end
                        if (idle_ticks_next >= tmo_limit_reg)
                        begin
                            timeout_next = 1'b1;
                        end
                    end
                    else
                    begin
                        idle_ticks_next = '0;
                    end
                end
                default:
                begin
                end
            endcase

            s1_next.irq = cause_of(ier_next, rx_count_next != '0, timeout_next, thre_next)
                          != u16rb_pkg::IIR_NONE;
        end
    end

    u16rb_ram u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (in_data.line_byte),
        .re    (rx_re),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    u16rb_ram u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (in_data.write_data),
        .re    (tx_re),
        .raddr (tx_head_reg),
        .rdata (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_limit_reg  <= u16rb_pkg::TMO_RESET;
            rx_count_reg   <= '0;
            rx_head_reg    <= '0;
            tx_count_reg   <= '0;
            tx_head_reg    <= '0;
            ier_reg        <= '0;
            lcr_reg        <= '0;
            divisor_reg    <= '0;
            fifo_on_reg    <= 1'b0;
            thre_reg       <= 1'b0;
            overrun_reg    <= 1'b0;
            idle_ticks_reg <= '0;
            timeout_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tmo_limit_reg <= cfg_wdata;
            end
            rx_count_reg   <= rx_count_next;
            rx_head_reg    <= rx_head_next;
            tx_count_reg   <= tx_count_next;
            tx_head_reg    <= tx_head_next;
            ier_reg        <= ier_next;
            lcr_reg        <= lcr_next;
            divisor_reg    <= divisor_next;
            fifo_on_reg    <= fifo_on_next;
            thre_reg       <= thre_next;
            overrun_reg    <= overrun_next;
            idle_ticks_reg <= idle_ticks_next;
            timeout_reg    <= timeout_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_ld)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // fifo bytes join the word as it leaves the first stage
    always_comb
    begin
        out_comb.read_data = s1_reg.use_rx ? rx_rdata : s1_reg.reg_data;
        out_comb.tx_byte   = s1_reg.use_tx ? tx_rdata : 8'h00;
        out_comb.tx_valid  = s1_reg.use_tx;
        out_comb.irq       = s1_reg.irq;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (out_ld)
        begin
            out_data_reg <= out_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_rx_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= (fifo_on_reg ? CW'(u16rb_pkg::FIFO_DEPTH) : CW'(1)))
        else $error("rx fifo count exceeds capacity");

    a_tx_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= (fifo_on_reg ? CW'(u16rb_pkg::FIFO_DEPTH) : CW'(1)))
        else $error("tx fifo count exceeds capacity");

    a_idle_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        (idle_ticks_reg != '0 || timeout_reg) |-> rx_count_reg != '0)
        else $error("timeout state set with empty rx fifo");

    a_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.tx_valid) |-> out_data_reg.read_data == 8'h00)
        else $error("transmit word carries read data");
`endif

endmodule
